[src/assert_macros.svh]
// Assertion helper macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/cfa_pkg.sv]
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared codes and types of the contiguous fit allocator.
// ----------------------------------------------------------------------------
package cfa_pkg;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_EVICT = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STRAT_FIRST = 2'd0,
    STRAT_BEST  = 2'd1,
    STRAT_NEXT  = 2'd2,
    STRAT_WORST = 2'd3
  } strat_t;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_NOEVICT = 2'd2;

  // Fields of one result beat.
  typedef struct packed {
    logic [6:0]  used_percent;
    logic [9:0]  hole_count;
    logic [15:0] evicted_key;
    logic [15:0] evicted_id;
    logic [9:0]  start_unit;
    logic [1:0]  status;
  } result_t;

endpackage

[src/cfa_percent.sv]
// ----------------------------------------------------------------------------
// cfa_percent
// Used share in percent, used * 100 / units, by reciprocal multiplication.
// ----------------------------------------------------------------------------
module cfa_percent #(
  parameter int CW = 11,
  parameter int UNITS = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [CW-1:0] used,
  output logic          done,
  output logic [6:0]    pct
);
  localparam int NW = CW + 7;
  localparam int SH = NW + $clog2(UNITS);
  localparam int MW = NW + 1;
  localparam int PW = NW + MW;
  // The rounded-up reciprocal is exact for every numerator below 2**NW.
  localparam longint RECIP_I = ((longint'(1) << SH) + longint'(UNITS) - 1) / longint'(UNITS);
  localparam logic [MW-1:0] RECIP = MW'(RECIP_I);

  logic [NW-1:0] num;
  logic [PW-1:0] prod;
  logic          stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= 1'b0;
      done  <= 1'b0;
    end else begin
      stage <= start;
      done  <= stage;
      if (start) num <= NW'(used) * NW'(100);
      if (stage) prod <= PW'(num) * PW'(RECIP);
    end
  end

  assign pct = prod[SH+6:SH];
endmodule

[src/contiguous_fit_allocator.sv]
// ----------------------------------------------------------------------------
// contiguous_fit_allocator
// Unit map allocator with first, best, next and worst fit placement.
// ----------------------------------------------------------------------------
// Input beats on s_axis carry kind in tuser and proc_id, alloc_size and
// age_key in tdata; each gives exactly one result beat on m_axis. The
// strategy register is written through cfg_we / cfg_data; the user writes it
// only while the block is idle, which the block does not enforce. The map
// lives in a memory of used/owner/age words with a registered read port.
// Each item takes three passes over all MEM_UNITS entries, one entry a
// cycle: a find pass (allocate: hole search, evict: oldest search), a modify
// pass (write the run, free the victim or clear the map) and a count pass for
// holes and usage, then a percentage multiply. The result is registered and
// s_axis_tready rises together with it, so a new beat is taken only once the
// last item's result is registered; the single memory port keeps the passes
// one after another. Reset clears the map by a sweep over all MEM_UNITS
// entries during which no item is accepted. A result waits in the output
// register while m_axis_tready is low; the next item is processed meanwhile
// and its result is held back until that register is free.
// ----------------------------------------------------------------------------
module contiguous_fit_allocator #(
  parameter int MEM_UNITS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  // proc_id[15:0], alloc_size[26:16], age_key[42:27], zero pad
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], start_unit[11:2], evicted_id[27:12], evicted_key[43:28],
  // hole_count[53:44], used_percent[60:54], zero pad
  output logic [63:0] m_axis_tdata
);
  localparam int AW = $clog2(MEM_UNITS);
  localparam int CW = AW + 1;
  localparam int LW = CW + 11;
  localparam logic [CW-1:0] NUNITS = CW'(MEM_UNITS);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_FIND, S_FEND, S_MOD, S_CNT, S_PCT, S_OUT
  } state_t;

  state_t state;
  logic [32:0] mem [MEM_UNITS];  // {used, owner, age}
  logic [32:0] rd;
  logic        mwe;
  logic [AW-1:0] waddr, raddr;
  logic [32:0] wdata;

  always_ff @(posedge clk) begin
    if (mwe) mem[waddr] <= wdata;
    rd <= mem[raddr];
  end

  cfa_pkg::strat_t strategy;
  logic [1:0]  kind;
  logic [15:0] pid, key;
  logic [10:0] size;
  logic [AW-1:0] nstart;

  logic [CW-1:0] ra;       // issue counter
  logic [CW-1:0] pa;       // address of rd
  logic          pv;       // rd valid
  logic [CW-1:0] run_s, run_l, best_s, best_l;
  logic          found, in_run;
  logic [15:0]   v_id, v_key;
  logic [CW-1:0] ucnt, holes;
  logic          prev_used;
  logic [1:0]    status;
  logic [AW-1:0] pos;
  logic          pct_go, pct_done;
  logic [6:0]    pct;
  cfa_pkg::result_t res;

  // A run is long enough for a nonzero request of sz units.
  function automatic logic fits(input logic [CW-1:0] len, input logic [10:0] sz);
    return (LW'(len) >= LW'(sz)) && (sz != '0);
  endfunction

  cfa_percent #(.CW(CW), .UNITS(MEM_UNITS)) u_pct (
    .clk, .rst, .start(pct_go), .used(ucnt), .done(pct_done), .pct
  );

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tdata  = {3'd0, res};

  // Next-fit scans from nstart circularly; scan index = (nstart + k) mod N.
  logic [CW-1:0] nf_add;
  logic [AW-1:0] scan_a;
  always_comb begin
    nf_add = CW'(nstart) + ra;
    if (nf_add >= NUNITS) nf_add = nf_add - NUNITS;
    scan_a = (strategy == cfa_pkg::STRAT_NEXT && kind == cfa_pkg::KIND_ALLOC)
             ? nf_add[AW-1:0] : ra[AW-1:0];
  end

  assign raddr = (state == S_FIND) ? scan_a : ra[AW-1:0];

  logic [CW-1:0] run_len_now;
  logic cur_free;
  assign cur_free = !rd[32];
  assign run_len_now = in_run ? run_l + 1'b1 : CW'(1);

  // Word written back by the modify pass.
  logic [32:0] mod_word;
  always_comb begin
    mod_word = rd;
    unique case (kind)
      cfa_pkg::KIND_ALLOC: begin
        if (status == cfa_pkg::ST_DONE && pa >= CW'(pos) &&
            LW'(CW'(pa - CW'(pos))) < LW'(size))
          mod_word = {1'b1, pid, key};
      end
      cfa_pkg::KIND_EVICT: begin
        if (status == cfa_pkg::ST_DONE && rd[32] && rd[31:16] == v_id)
          mod_word[32] = 1'b0;
      end
      cfa_pkg::KIND_CLEAR: mod_word[32] = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      ra <= '0;
      strategy <= cfa_pkg::STRAT_FIRST;
      nstart <= '0;
      m_axis_tvalid <= 1'b0;
      mwe <= 1'b0;
      pct_go <= 1'b0;
      pv <= 1'b0;
    end else begin
      mwe <= 1'b0;
      pct_go <= 1'b0;
      if (cfg_we) strategy <= cfa_pkg::strat_t'(cfg_data);
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_CLR: begin
          mwe <= 1'b1; waddr <= ra[AW-1:0]; wdata <= '0;
          ra <= ra + 1'b1;
          if (ra == NUNITS - 1'b1) begin
            state <= S_IDLE;
            ra <= '0;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            kind <= s_axis_tuser;
            pid  <= s_axis_tdata[15:0];
            size <= s_axis_tdata[26:16];
            key  <= s_axis_tdata[42:27];
            ra <= '0; pv <= 1'b0;
            found <= 1'b0; in_run <= 1'b0;
            best_s <= '0; best_l <= '0; status <= cfa_pkg::ST_DONE;
            pos <= '0;
            state <= S_FIND;
          end
        end
        S_FIND: begin
          // Issue reads in scan order and consume each in the next cycle, from rd.
          if (ra != NUNITS) begin
            ra <= ra + 1'b1;
          end
          pv <= (ra != NUNITS);
          pa <= CW'(scan_a);
          if (pv) begin
            if (kind == cfa_pkg::KIND_ALLOC) begin
              if (strategy == cfa_pkg::STRAT_NEXT) begin
                // Runs are cut where the circular scan wraps past the end.
                if (cur_free && !(in_run && pa == '0)) begin
                  if (!in_run) run_s <= pa;
                  run_l <= run_len_now;
                  in_run <= 1'b1;
                  if (!found && fits(run_len_now, size)) begin
                    found <= 1'b1;
                    best_s <= in_run ? run_s : pa;
                  end
                end else if (cur_free) begin
                  run_s <= pa; run_l <= CW'(1); in_run <= 1'b1;
                  if (!found && fits(CW'(1), size)) begin
                    found <= 1'b1; best_s <= pa;
                  end
                end else begin
                  in_run <= 1'b0;
                end
              end else begin
                // Hole ends when a used unit is seen; the tail is closed in S_FEND.
                if (cur_free) begin
                  if (!in_run) run_s <= pa;
                  run_l <= run_len_now;
                  in_run <= 1'b1;
                end else begin
                  in_run <= 1'b0;
                  if (in_run) begin
                    if (fits(run_l, size) &&
                        (!found ||
                         (strategy == cfa_pkg::STRAT_BEST && run_l <= best_l) ||
                         (strategy == cfa_pkg::STRAT_WORST && run_l > best_l))) begin
                      found <= 1'b1; best_s <= run_s; best_l <= run_l;
                    end
                  end
                end
              end
            end else if (kind == cfa_pkg::KIND_EVICT) begin
              if (rd[32] && (!found || rd[15:0] < v_key)) begin
                found <= 1'b1; v_id <= rd[31:16]; v_key <= rd[15:0];
              end
            end
          end
          if (!pv && ra == NUNITS) state <= S_FEND;
        end
        S_FEND: begin
          ra <= '0; pv <= 1'b0;
          in_run <= 1'b0; ucnt <= '0; holes <= '0; prev_used <= 1'b1;
          state <= S_MOD;
          if (kind == cfa_pkg::KIND_ALLOC) begin
            if (strategy != cfa_pkg::STRAT_NEXT && !found && in_run &&
                fits(run_l, size)) begin
              found <= 1'b1; pos <= run_s[AW-1:0]; best_l <= run_l;
            end else if (strategy != cfa_pkg::STRAT_NEXT && in_run &&
                fits(run_l, size) &&
                ((strategy == cfa_pkg::STRAT_BEST && run_l <= best_l) ||
                 (strategy == cfa_pkg::STRAT_WORST && run_l > best_l))) begin
              pos <= run_s[AW-1:0];
            end else begin
              pos <= best_s[AW-1:0];
            end
            if (!found && !(strategy != cfa_pkg::STRAT_NEXT && in_run &&
                fits(run_l, size)))
              status <= cfa_pkg::ST_NOFIT;
          end else if (kind == cfa_pkg::KIND_EVICT) begin
            if (!found) status <= cfa_pkg::ST_NOEVICT;
          end
        end
        S_MOD: begin
          // Read-modify-write of every unit; the write is registered from rd via mod_word.
          if (ra != NUNITS) ra <= ra + 1'b1;
          pv <= (ra != NUNITS);
          pa <= ra;
          if (pv) begin
            mwe <= 1'b1; waddr <= pa[AW-1:0]; wdata <= mod_word;
          end
          if (!pv && ra == NUNITS) begin
            ra <= '0;
            state <= S_CNT;
          end
        end
        S_CNT: begin
          if (ra != NUNITS) ra <= ra + 1'b1;
          pv <= (ra != NUNITS);
          if (pv) begin
            if (rd[32]) ucnt <= ucnt + 1'b1;
            else if (prev_used) holes <= holes + 1'b1;
            prev_used <= rd[32];
          end
          if (!pv && ra == NUNITS && !mwe) begin
            pct_go <= 1'b1;
            state <= S_PCT;
          end
        end
        S_PCT: begin
          if (pct_done) state <= S_OUT;
        end
        S_OUT: begin
          if (!m_axis_tvalid) begin
            res.status <= status;
            res.start_unit <= (kind == cfa_pkg::KIND_ALLOC && status == cfa_pkg::ST_DONE)
                              ? 10'(pos) : '0;
            res.evicted_id  <= (kind == cfa_pkg::KIND_EVICT && found) ? v_id : '0;
            res.evicted_key <= (kind == cfa_pkg::KIND_EVICT && found) ? v_key : '0;
            res.hole_count <= 10'(holes);
            res.used_percent <= pct;
            m_axis_tvalid <= 1'b1;
            if (kind == cfa_pkg::KIND_ALLOC)
              nstart <= (status == cfa_pkg::ST_DONE) ? pos : '0;
            else if (kind == cfa_pkg::KIND_CLEAR)
              nstart <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[src/cfa_checker.sv]
// ----------------------------------------------------------------------------
// cfa_checker
// Port-level checks of the contiguous fit allocator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cfa_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);
  `ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")
  `ASSERT_NEXT(a_keep, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
  `ASSERT_IMPL(a_status, clk, rst, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3, "bad status code")
  `ASSERT_IMPL(a_pct, clk, rst, m_axis_tvalid, m_axis_tdata[60:54] <= 7'd100, "percentage above 100")
  `ASSERT_NEXT(a_busy, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")
endmodule

bind contiguous_fit_allocator cfa_port_checks u_cfa_port_checks (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

[dv/cfa_checker.sv]
// ----------------------------------------------------------------------------
// cfa_checker
// Watches the input and result streams of the allocator, keeps its own copy
// of the unit map, predicts each result beat and compares it field by field.
// ----------------------------------------------------------------------------
module cfa_checker #(
  parameter int MEM_UNITS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,
  input  logic [47:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  bit               map_used [MEM_UNITS];
  logic [15:0]      map_owner [MEM_UNITS];
  logic [15:0]      map_age [MEM_UNITS];
  int               next_pos;
  cfa_pkg::strat_t  placement;
  cfa_pkg::result_t expected_results[$];

  function automatic int free_run(int i);
    int n;
    n = 0;
    while (i < MEM_UNITS && !map_used[i]) begin
      n++;
      i++;
    end
    return n;
  endfunction

  // First, best and worst fit over maximal holes.
  function automatic bit place_in_holes(cfa_pkg::strat_t mode, int size, output int where);
    bit found;
    int best_len, best_pos, i, len;
    found = 0;
    best_len = 0;
    best_pos = 0;
    i = 0;
    where = 0;
    while (i < MEM_UNITS) begin
      if (map_used[i]) begin
        i++;
      end else begin
        len = free_run(i);
        if (len >= size) begin
          if (mode == cfa_pkg::STRAT_FIRST) begin
            where = i;
            return 1;
          end
          if (!found || (mode == cfa_pkg::STRAT_BEST && len <= best_len) ||
              (mode == cfa_pkg::STRAT_WORST && len > best_len)) begin
            found = 1;
            best_len = len;
            best_pos = i;
          end
        end
        i += len;
      end
    end
    where = best_pos;
    return found;
  endfunction

  // Circular scan from the last start; runs stop at the end and at the start.
  function automatic bit place_next(int size, output int where);
    int origin, i, s, run;
    origin = (next_pos < MEM_UNITS) ? next_pos : 0;
    i = origin;
    where = 0;
    if (!map_used[i] && free_run(i) >= size) begin
      where = i;
      return 1;
    end
    i = (i >= MEM_UNITS - 1) ? 0 : i + 1;
    while (i != origin) begin
      if (!map_used[i]) begin
        s = i;
        run = 0;
        while (i < MEM_UNITS && !map_used[i] && i != origin) begin
          run++;
          i++;
        end
        if (run >= size) begin
          where = s;
          return 1;
        end
      end
      if (i != origin) i = (i >= MEM_UNITS - 1) ? 0 : i + 1;
    end
    return 0;
  endfunction

  function automatic cfa_pkg::result_t predict_result(logic [1:0] user, logic [47:0] beat);
    cfa_pkg::result_t r;
    cfa_pkg::kind_t   kind;
    logic [15:0] id, key, victim;
    int size, pos, at, used, holes, i;
    bit ok, found;
    kind = cfa_pkg::kind_t'(user);
    id   = beat[15:0];
    size = int'(beat[26:16]);
    key  = beat[42:27];
    r = '0;
    r.status = cfa_pkg::ST_DONE;
    case (kind)
      cfa_pkg::KIND_ALLOC: begin
        ok = 0;
        pos = 0;
        if (size != 0) begin
          if (placement == cfa_pkg::STRAT_NEXT) ok = place_next(size, pos);
          else ok = place_in_holes(placement, size, pos);
        end
        if (ok) begin
          for (i = 0; i < size && pos + i < MEM_UNITS; i++) begin
            map_used[pos + i] = 1;
            map_owner[pos + i] = id;
            map_age[pos + i] = key;
          end
          r.start_unit = 10'(pos);
          next_pos = pos;
        end else begin
          r.status = cfa_pkg::ST_NOFIT;
          next_pos = 0;
        end
      end
      cfa_pkg::KIND_EVICT: begin
        found = 0;
        at = 0;
        for (i = 0; i < MEM_UNITS; i++)
          if (map_used[i] && (!found || map_age[i] < map_age[at])) begin
            found = 1;
            at = i;
          end
        if (found) begin
          victim = map_owner[at];
          r.evicted_id = victim;
          r.evicted_key = map_age[at];
          for (i = 0; i < MEM_UNITS; i++)
            if (map_used[i] && map_owner[i] == victim) map_used[i] = 0;
        end else begin
          r.status = cfa_pkg::ST_NOEVICT;
        end
      end
      cfa_pkg::KIND_CLEAR: begin
        for (i = 0; i < MEM_UNITS; i++) map_used[i] = 0;
        next_pos = 0;
      end
      default: ;
    endcase
    used = 0;
    holes = 0;
    for (i = 0; i < MEM_UNITS; i++) begin
      used += int'(map_used[i]);
      if (!map_used[i] && (i == 0 || map_used[i - 1])) holes++;
    end
    r.hole_count = 10'(holes);
    r.used_percent = 7'((used * 100) / MEM_UNITS);
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    result_count = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    cfa_pkg::result_t got, want;
    if (rst) begin
      for (int i = 0; i < MEM_UNITS; i++) map_used[i] = 0;
      next_pos = 0;
      placement = cfa_pkg::STRAT_FIRST;
      expected_results.delete();
    end else begin
      if (cfg_we) placement = cfa_pkg::strat_t'(cfg_data);
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(predict_result(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = cfa_pkg::result_t'(m_axis_tdata[60:0]);
        result_count++;
        if (m_axis_tdata[63:61] != 0)
          report_mismatch("pad", int'(m_axis_tdata[63:61]), 0);
        if (expected_results.size() == 0) begin
          $display("[%0t] result beat with nothing expected", $realtime);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.status != want.status) report_mismatch("status", got.status, want.status);
          if (got.start_unit != want.start_unit)
            report_mismatch("start_unit", got.start_unit, want.start_unit);
          if (got.evicted_id != want.evicted_id)
            report_mismatch("evicted_id", got.evicted_id, want.evicted_id);
          if (got.evicted_key != want.evicted_key)
            report_mismatch("evicted_key", got.evicted_key, want.evicted_key);
          if (got.hole_count != want.hole_count)
            report_mismatch("hole_count", got.hole_count, want.hole_count);
          if (got.used_percent != want.used_percent)
            report_mismatch("used_percent", got.used_percent, want.used_percent);
        end
      end
    end
    pending_count = expected_results.size();
  end

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives allocate, evict, clear and no-op beats into the allocator under all
// four placement strategies, with random gaps on both streams.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MEM_UNITS = 1024;
  localparam int ITEM_CYCLES = 3 * MEM_UNITS + 40;
  localparam int RANDOM_ITEMS = 528;
  // Slowest run: each item its own cycles plus both sides' longest gaps.
  localparam longint CYCLE_LIMIT = 4 * (60 + RANDOM_ITEMS + 20) * (ITEM_CYCLES + 40)
                                   + 4 * MEM_UNITS;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [1:0]  cfg_data = '0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser = '0;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [63:0] m_axis_tdata;
  int          fail_count, pending_count, result_count;
  longint      cycle_count = 0;
  bit          quiet_phase = 0;
  int          alloc_beats = 0, evict_beats = 0, clear_beats = 0;
  logic [15:0] age_counter = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  contiguous_fit_allocator #(.MEM_UNITS(MEM_UNITS)) dut (.*);

  cfa_checker #(.MEM_UNITS(MEM_UNITS)) checker_i (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: ready in random bursts, steady at the end of the run.
  initial begin
    int n;
    m_axis_tready <= 0;
    @(posedge clk);
    forever begin
      if (quiet_phase) begin
        m_axis_tready <= 1;
        @(posedge clk);
      end else begin
        n = $urandom_range(1, 18);
        m_axis_tready <= $urandom_range(0, 2) != 0;
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic send_beat(cfa_pkg::kind_t kind, logic [15:0] id, logic [10:0] size,
                           logic [15:0] key);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {5'b0, key, size, id};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    case (kind)
      cfa_pkg::KIND_ALLOC: alloc_beats++;
      cfa_pkg::KIND_EVICT: evict_beats++;
      cfa_pkg::KIND_CLEAR: clear_beats++;
      default: ;
    endcase
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (ITEM_CYCLES) @(posedge clk);
  endtask

  task automatic set_strategy(cfa_pkg::strat_t mode);
    cfg_we   <= 1;
    cfg_data <= mode;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // Mostly modest allocations with an occasional large one, and evictions
  // often enough that the map keeps fragmenting instead of just filling.
  task automatic random_beat();
    int pick;
    logic [10:0] size;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      case ($urandom_range(0, 9))
        0: size = 11'($urandom_range(0, 2047));
        1: size = 11'($urandom_range(257, 1024));
        default: size = 11'($urandom_range(1, 96));
      endcase
      age_counter = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'(age_counter + 1);
      send_beat(cfa_pkg::KIND_ALLOC, 16'($urandom_range(0, 15) == 0 ? $urandom :
                $urandom_range(0, 40)), size, age_counter);
    end else if (pick < 95) begin
      send_beat(cfa_pkg::KIND_EVICT, 16'($urandom), 11'($urandom), 16'($urandom));
    end else if (pick < 98) begin
      send_beat(cfa_pkg::KIND_CLEAR, 16'($urandom), 11'($urandom), 16'($urandom));
    end else begin
      send_beat(cfa_pkg::KIND_NOP, 16'($urandom), 11'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    cfa_pkg::strat_t modes[4];
    modes = '{cfa_pkg::STRAT_FIRST, cfa_pkg::STRAT_BEST, cfa_pkg::STRAT_NEXT,
              cfa_pkg::STRAT_WORST};
    repeat (8) @(posedge clk);
    rst <= 0;

    // Directed: empty map, extremes of every field, all strategies.
    send_beat(cfa_pkg::KIND_EVICT, 16'h0, 11'd0, 16'h0);
    send_beat(cfa_pkg::KIND_ALLOC, 16'h1, 11'd0, 16'h5);
    send_beat(cfa_pkg::KIND_ALLOC, 16'h1, 11'd1025, 16'h5);
    send_beat(cfa_pkg::KIND_ALLOC, 16'h1, 11'h7FF, 16'h5);
    send_beat(cfa_pkg::KIND_ALLOC, 16'hFFFF, 11'd1024, 16'hFFFF);
    send_beat(cfa_pkg::KIND_ALLOC, 16'h2, 11'd1, 16'h0);
    send_beat(cfa_pkg::KIND_EVICT, 16'hFFFF, 11'h7FF, 16'hFFFF);
    send_beat(cfa_pkg::KIND_NOP, 16'hFFFF, 11'h7FF, 16'hFFFF);
    send_beat(cfa_pkg::KIND_CLEAR, 16'hFFFF, 11'h7FF, 16'hFFFF);
    foreach (modes[m]) begin
      drain_results();
      set_strategy(modes[m]);
      // Holes of 100, 50 and 100 units, then a request that fits all three.
      send_beat(cfa_pkg::KIND_ALLOC, 16'd10, 11'd100, 16'd30);
      send_beat(cfa_pkg::KIND_ALLOC, 16'd11, 11'd10, 16'd31);
      send_beat(cfa_pkg::KIND_ALLOC, 16'd12, 11'd50, 16'd20);
      send_beat(cfa_pkg::KIND_ALLOC, 16'd13, 11'd10, 16'd32);
      send_beat(cfa_pkg::KIND_ALLOC, 16'd10, 11'd100, 16'd33);
      send_beat(cfa_pkg::KIND_ALLOC, 16'd14, 11'd10, 16'd34);
      send_beat(cfa_pkg::KIND_EVICT, 16'd0, 11'd0, 16'd0);
      send_beat(cfa_pkg::KIND_EVICT, 16'd0, 11'd0, 16'd0);
      send_beat(cfa_pkg::KIND_ALLOC, 16'd15, 11'd40, 16'd35);
      send_beat(cfa_pkg::KIND_ALLOC, 16'd16, 11'd800, 16'd36);
      send_beat(cfa_pkg::KIND_CLEAR, 16'd0, 11'd0, 16'd0);
    end

    // Random part in phases with random strategies, the last under worst fit with no gaps.
    for (int phase = 0; phase < 8; phase++) begin
      drain_results();
      set_strategy(phase == 7 ? cfa_pkg::STRAT_WORST
                              : cfa_pkg::strat_t'($urandom_range(0, 3)));
      if (phase == 7) quiet_phase = 1;
      repeat (RANDOM_ITEMS / 8) random_beat();
    end
    s_axis_tvalid <= 0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (ITEM_CYCLES) @(posedge clk);
    $display("covered %0d allocate, %0d evict and %0d clear beats over four strategies",
             alloc_beats, evict_beats, clear_beats);
    $display("%0d result beats checked", result_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/cfa_pkg.sv
src/cfa_percent.sv
src/contiguous_fit_allocator.sv
src/cfa_checker.sv
dv/cfa_checker.sv
dv/testbench.sv
